@@ src/catmull_rom_polyline_resampler_core_assert.svh @@
// ----------------------------------------------------------------------------
// catmull-rom resampler assertion macros
// clocked assertion wrappers that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_POLYLINE_RESAMPLER_CORE_ASSERT_SVH
`define CATMULL_ROM_POLYLINE_RESAMPLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define CRPR_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: name");
`define CRPR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: name");
`else
`define CRPR_ASSERT(name, clk, rst_n, prop)
`define CRPR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

@@ src/crpr_pkg.sv @@
// ----------------------------------------------------------------------------
// crpr_pkg
// shared constants, register codes and evaluator opcodes of the resampler
// ----------------------------------------------------------------------------
package crpr_pkg;

    localparam int COORD_WIDTH_DEF    = 24;
    localparam int MAX_NEW_POINTS_DEF = 61;

    localparam int NPTS_WIDTH   = 6;
    localparam int TSTEP_WIDTH  = 17;
    localparam int TACC_WIDTH   = TSTEP_WIDTH + NPTS_WIDTH;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [NPTS_WIDTH-1:0]  NPTS_RESET  = 6'd8;
    localparam logic [TSTEP_WIDTH-1:0] TSTEP_RESET = 17'd8192;
    localparam logic [TSTEP_WIDTH-1:0] T_ONE       = 17'h10000;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_NUM_NEW_POINTS = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_T_STEP         = 2'd1;

    typedef enum logic [2:0] {
        EV_HOLD,
        EV_LOAD,
        EV_MUL,
        EV_ADD_C,
        EV_ADD_B,
        EV_ADD_A
    } t_eval_op;

endpackage

@@ src/crpr_spline_unit.sv @@
// ----------------------------------------------------------------------------
// crpr_spline_unit
// shared multiply-accumulate unit that evaluates one cubic coordinate by
// horner steps, then rounds and saturates the result
// ----------------------------------------------------------------------------
module crpr_spline_unit #(
    parameter int COORD_WIDTH = crpr_pkg::COORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  crpr_pkg::t_eval_op                  i_op,
    input  logic signed [COORD_WIDTH-1:0]       i_p0,
    input  logic signed [COORD_WIDTH-1:0]       i_p1,
    input  logic signed [COORD_WIDTH-1:0]       i_p2,
    input  logic signed [COORD_WIDTH-1:0]       i_p3,
    input  logic [crpr_pkg::TSTEP_WIDTH-1:0]    i_t,
    output logic signed [COORD_WIDTH-1:0]       o_result
);

    localparam int SW = COORD_WIDTH + 5;
    localparam int PW = SW + crpr_pkg::TSTEP_WIDTH + 1;

    logic signed [SW-1:0] w_p0, w_p1, w_p2, w_p3;
    logic signed [SW-1:0] w_a, w_b, w_c, w_d;
    logic signed [crpr_pkg::TSTEP_WIDTH:0] w_t;
    logic signed [PW-1:0] w_prod_rnd;
    logic signed [SW-1:0] w_r16;
    logic signed [SW-1:0] w_s3_rnd;
    logic signed [SW-1:0] w_r1;

    logic signed [SW-1:0] r_acc;
    logic signed [PW-1:0] r_prod;

    assign w_p0 = SW'(i_p0);
    assign w_p1 = SW'(i_p1);
    assign w_p2 = SW'(i_p2);
    assign w_p3 = SW'(i_p3);

    assign w_a = w_p1 <<< 1;
    assign w_b = w_p2 - w_p0;
    assign w_c = (w_p0 <<< 1) - (w_p1 <<< 2) - w_p1 + (w_p2 <<< 2) - w_p3;
    assign w_d = (w_p1 <<< 1) + w_p1 - (w_p2 <<< 1) - w_p2 + w_p3 - w_p0;

    assign w_t        = $signed({1'b0, i_t});
    assign w_prod_rnd = r_prod + PW'(32768);
    assign w_r16      = SW'(w_prod_rnd >>> 16);
    assign w_s3_rnd   = r_acc + SW'(1);
    assign w_r1       = w_s3_rnd >>> 1;

    always_comb begin
        if (w_r1[SW-1:COORD_WIDTH-1] == '0 || w_r1[SW-1:COORD_WIDTH-1] == '1) begin
            o_result = w_r1[COORD_WIDTH-1:0];
        end else if (w_r1[SW-1]) begin
            o_result = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            o_result = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            crpr_pkg::EV_HOLD:  ;
            crpr_pkg::EV_LOAD:  r_acc  <= w_d;
            crpr_pkg::EV_MUL:   r_prod <= r_acc * w_t;
            crpr_pkg::EV_ADD_C: r_acc  <= w_c + w_r16;
            crpr_pkg::EV_ADD_B: r_acc  <= w_b + w_r16;
            crpr_pkg::EV_ADD_A: r_acc  <= w_a + w_r16;
            default: ;
        endcase
    end

endmodule

@@ src/catmull_rom_polyline_resampler_core.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_polyline_resampler_core
// a key point is accepted in idle; a passed key point is loaded into the output register from the head or tail state
// each curve point is evaluated on the one shared multiplier in steps: 1 load, 3 multiply/add
//   pairs and 1 round per coordinate, then an output step that waits while the output is stalled
// a new key point is taken once the last result of the previous one sits in the output
// reset: synchronous active low, clears the window count and loads register defaults
// ----------------------------------------------------------------------------
`include "catmull_rom_polyline_resampler_core_assert.svh"

module catmull_rom_polyline_resampler_core #(
    parameter int COORD_WIDTH    = crpr_pkg::COORD_WIDTH_DEF,
    parameter int MAX_NEW_POINTS = crpr_pkg::MAX_NEW_POINTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]         i_key_x,
    input  logic signed [COORD_WIDTH-1:0]         i_key_y,
    input  logic                                  i_key_last,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [COORD_WIDTH-1:0]         o_curve_x,
    output logic signed [COORD_WIDTH-1:0]         o_curve_y,
    output logic                                  o_curve_last,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [crpr_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [crpr_pkg::TSTEP_WIDTH-1:0]      i_cfg_data
);

    localparam int NW = crpr_pkg::NPTS_WIDTH;
    localparam int TW = crpr_pkg::TSTEP_WIDTH;
    localparam int AW = crpr_pkg::TACC_WIDTH;
    localparam logic [NW-1:0] MAX_NP = NW'(MAX_NEW_POINTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_LOAD,
        ST_MUL,
        ST_ADD,
        ST_FIN,
        ST_OUT,
        ST_TAIL
    } t_state;

    t_state r_state;
    logic [NW-1:0] r_npts;
    logic [TW-1:0] r_tstep;
    logic [2:0]    r_points_seen;
    logic [2:0]    r_cnt;
    logic          r_last;
    logic [1:0]    r_idx;
    logic [1:0]    r_step;
    logic          r_coord;
    logic [NW-1:0] r_j;
    logic [AW-1:0] r_tacc;
    logic signed [COORD_WIDTH-1:0] r_win_x [4];
    logic signed [COORD_WIDTH-1:0] r_win_y [4];
    logic signed [COORD_WIDTH-1:0] r_res_x;
    logic signed [COORD_WIDTH-1:0] r_res_y;
    logic          r_out_valid;
    logic signed [COORD_WIDTH-1:0] r_out_x;
    logic signed [COORD_WIDTH-1:0] r_out_y;
    logic          r_out_last;

    logic          w_in_acc;
    logic          w_out_free;
    logic          w_out_load;
    logic [2:0]    w_cnt_next;
    logic [NW-1:0] w_npts_eff;
    logic [TW-1:0] w_t;
    logic          w_tail_end;
    t_state        w_after_curve;
    crpr_pkg::t_eval_op w_op;
    logic signed [COORD_WIDTH-1:0] w_p [4];
    logic signed [COORD_WIDTH-1:0] w_result;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_curve_x   = r_out_x;
    assign o_curve_y   = r_out_y;
    assign o_curve_last = r_out_last;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = w_out_free
                        && (r_state == ST_HEAD || r_state == ST_OUT || r_state == ST_TAIL);
    assign w_cnt_next = (r_points_seen < 3'd4) ? r_points_seen + 3'd1 : 3'd4;
    assign w_npts_eff = (r_npts > MAX_NP) ? MAX_NP : r_npts;
    assign w_t        = (r_tacc > AW'(crpr_pkg::T_ONE)) ? crpr_pkg::T_ONE : r_tacc[TW-1:0];
    assign w_tail_end = ({1'b0, r_idx} == r_cnt - 3'd1);
    assign w_after_curve = r_last ? ST_TAIL : ST_IDLE;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_p[k] = r_coord ? r_win_y[k] : r_win_x[k];
        end
    end

    always_comb begin
        unique case (r_state)
            ST_LOAD: w_op = crpr_pkg::EV_LOAD;
            ST_MUL:  w_op = crpr_pkg::EV_MUL;
            ST_ADD: begin
                case (r_step)
                    2'd0:    w_op = crpr_pkg::EV_ADD_C;
                    2'd1:    w_op = crpr_pkg::EV_ADD_B;
                    default: w_op = crpr_pkg::EV_ADD_A;
                endcase
            end
            default: w_op = crpr_pkg::EV_HOLD;
        endcase
    end

    crpr_spline_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_spline (
        .i_clk    (i_clk),
        .i_op     (w_op),
        .i_p0     (w_p[0]),
        .i_p1     (w_p[1]),
        .i_p2     (w_p[2]),
        .i_p3     (w_p[3]),
        .i_t      (w_t),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_npts        <= crpr_pkg::NPTS_RESET;
            r_tstep       <= crpr_pkg::TSTEP_RESET;
            r_points_seen <= 3'd0;
            r_cnt         <= 3'd1;
            r_last        <= 1'b0;
            r_idx         <= 2'd0;
            r_step        <= 2'd0;
            r_coord       <= 1'b0;
            r_j           <= '0;
            r_tacc        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    crpr_pkg::CFG_NUM_NEW_POINTS: r_npts  <= i_cfg_data[NW-1:0];
                    crpr_pkg::CFG_T_STEP:         r_tstep <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (r_points_seen < 3'd4) begin
                            r_win_x[r_points_seen[1:0]] <= i_key_x;
                            r_win_y[r_points_seen[1:0]] <= i_key_y;
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                r_win_x[k] <= r_win_x[k+1];
                                r_win_y[k] <= r_win_y[k+1];
                            end
                            r_win_x[3] <= i_key_x;
                            r_win_y[3] <= i_key_y;
                        end
                        r_cnt         <= w_cnt_next;
                        r_last        <= i_key_last;
                        r_points_seen <= i_key_last ? 3'd0 : w_cnt_next;
                        r_idx         <= (w_cnt_next == 3'd4) ? 2'd2 : 2'd0;
                        r_j           <= '0;
                        r_tacc        <= '0;
                        r_coord       <= 1'b0;
                        if (r_points_seen == 3'd3) begin
                            r_state <= ST_HEAD;
                        end else if (w_cnt_next == 3'd4 && w_npts_eff != '0) begin
                            r_state <= ST_LOAD;
                        end else if (i_key_last) begin
                            r_state <= ST_TAIL;
                        end
                    end
                end
                ST_HEAD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_win_x[0];
                        r_out_y     <= r_win_y[0];
                        r_out_last  <= 1'b0;
                        r_state     <= (w_npts_eff != '0) ? ST_LOAD : w_after_curve;
                    end
                end
                ST_LOAD: begin
                    r_step  <= 2'd0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    if (r_step == 2'd2) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= ST_MUL;
                    end
                end
                ST_FIN: begin
                    if (!r_coord) begin
                        r_res_x <= w_result;
                        r_coord <= 1'b1;
                        r_state <= ST_LOAD;
                    end else begin
                        r_res_y <= w_result;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_res_x;
                        r_out_y     <= r_res_y;
                        r_out_last  <= 1'b0;
                        r_coord     <= 1'b0;
                        r_j         <= r_j + NW'(1);
                        r_tacc      <= r_tacc + AW'(r_tstep);
                        r_state     <= (r_j + NW'(1) == w_npts_eff) ? w_after_curve : ST_LOAD;
                    end
                end
                ST_TAIL: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_win_x[r_idx];
                        r_out_y     <= r_win_y[r_idx];
                        r_out_last  <= w_tail_end;
                        r_idx       <= r_idx + 2'd1;
                        if (w_tail_end) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `CRPR_ASSERT(a_points_seen_max, i_clk, i_rst_n, r_points_seen <= 3'd4)
    `CRPR_ASSERT(a_tail_idx_in_window, i_clk, i_rst_n, r_state != ST_TAIL || 3'(r_idx) < r_cnt)
    `CRPR_ASSERT_NEXT(a_last_ends_polyline, i_clk, i_rst_n, r_state == ST_TAIL && w_out_free && w_tail_end, r_state == ST_IDLE && r_out_valid && r_out_last)

endmodule
